// File: rtl/adcwmm_pkg.sv
package adcwmm_pkg;

  // Controller states.
  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_SCALE,
    ST_EMIT
  } ctrl_state_e;

  // Which window statistic goes through the shared scaling multiplier.
  typedef enum logic [1:0] {
    SEL_MEAN,
    SEL_MIN,
    SEL_MAX
  } scale_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;     // a sample word is taken this cycle
    logic       first;      // that word opens a new window
    logic       div_step;   // replace the sum by the window mean
    logic       scale_en;   // scale the selected statistic to millivolts
    scale_sel_e scale_sel;
    logic       load_out;   // load the result registers
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // the result registers can take a new word this cycle
  } dp_status_t;

endpackage

// File: rtl/adcwmm_ctrl.sv
module adcwmm_ctrl #(
  parameter int unsigned WINDOW = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  adcwmm_pkg::dp_status_t status_i,
  output adcwmm_pkg::ctrl_cmd_t  cmd_o
);
  import adcwmm_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW);

  ctrl_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  scale_sel_e        sel_q, sel_d;

  logic accept;
  logic last_sample;

  assign accept      = in_valid_i && (state_q == ST_ACCUM);
  assign last_sample = (cnt_q == CNT_W'(WINDOW - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACCUM: begin
        if (accept && last_sample) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        if (sel_q == SEL_MAX) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_ACCUM;
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  // Counters.
  always_comb begin
    cnt_d  = cnt_q;
    sel_d  = sel_q;
    if (accept) begin
      cnt_d = last_sample ? '0 : cnt_q + 1'b1;
    end
    if (state_q == ST_SCALE) begin
      unique case (sel_q)
        SEL_MEAN: sel_d = SEL_MIN;
        SEL_MIN:  sel_d = SEL_MAX;
        default:  sel_d = SEL_MEAN;
      endcase
    end
  end

  // Outputs.
  always_comb begin
    cmd_o           = '0;
    cmd_o.scale_sel = sel_q;
    in_stall_o      = 1'b1;
    unique case (state_q)
      ST_ACCUM: begin
        in_stall_o      = 1'b0;
        cmd_o.accept    = accept;
        cmd_o.first     = (cnt_q == '0);
      end
      ST_DIVIDE: cmd_o.div_step = 1'b1;
      ST_SCALE:  cmd_o.scale_en = 1'b1;
      ST_EMIT:   cmd_o.load_out = status_i.out_free;
      default:   in_stall_o     = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      cnt_q   <= '0;
      sel_q   <= SEL_MEAN;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// File: rtl/adcwmm_dp.sv
module adcwmm_dp #(
  parameter int unsigned WINDOW      = 20,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [11:0]            sample_i,
  input  adcwmm_pkg::ctrl_cmd_t  cmd_i,
  output adcwmm_pkg::dp_status_t status_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [11:0]            mean_mv_o,
  output logic [11:0]            min_mv_o,
  output logic [11:0]            max_mv_o,
  output logic [1:0]             mean_volts_digit_o,
  output logic [3:0]             mean_tenths_digit_o,
  output logic [3:0]             mean_hundredths_digit_o,
  output logic [1:0]             min_volts_digit_o,
  output logic [3:0]             min_tenths_digit_o,
  output logic [3:0]             min_hundredths_digit_o,
  output logic [1:0]             max_volts_digit_o,
  output logic [3:0]             max_tenths_digit_o,
  output logic [3:0]             max_hundredths_digit_o
);
  import adcwmm_pkg::*;

  localparam int unsigned SUM_W     = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned MV_SCALE  = 52800;
  // Rounded-up reciprocal of the window length; exact for every sum below 2^SUM_W.
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int unsigned DIV_MUL   = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int unsigned PROD_W    = 2 * SUM_W + 1;

  typedef struct packed {
    logic [1:0] volts;
    logic [3:0] tenths;
    logic [3:0] hundredths;
  } digits_t;

  // Splits a millivolt value below 4000 into volts, tenths and hundredths.
  function automatic digits_t split_mv(input logic [11:0] mv);
    digits_t    d;
    logic [11:0] r1;
    logic [9:0]  r2;
    d = '0;
    for (int k = 1; k <= 3; k++) begin
      if (mv >= 12'(k * 1000)) d.volts = 2'(k);
    end
    r1 = mv - 12'(32'(d.volts) * 1000);
    for (int k = 1; k <= 9; k++) begin
      if (r1 >= 12'(k * 100)) d.tenths = 4'(k);
    end
    r2 = 10'(r1 - 12'(32'(d.tenths) * 100));
    for (int k = 1; k <= 9; k++) begin
      if (r2 >= 10'(k * 10)) d.hundredths = 4'(k);
    end
    return d;
  endfunction

  logic [SAMPLE_BITS-1:0] s;
  logic [SAMPLE_BITS-1:0] min_q, max_q;
  logic [SUM_W-1:0]       sum_q;
  logic [PROD_W-1:0]      div_prod;

  logic [11:0] code;
  logic [27:0] prod;
  logic [11:0] mean_mv_q, min_mv_q, max_mv_q;
  logic        out_valid_q;
  digits_t     mean_dg, min_dg, max_dg;

  assign s        = sample_i[SAMPLE_BITS-1:0];
  assign div_prod = PROD_W'(sum_q) * PROD_W'(DIV_MUL);

  // Running statistics; once the window closes, the sum register takes the
  // mean, found by multiplying with the reciprocal of the window length.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (cmd_i.first) begin
        min_q <= s;
        max_q <= s;
        sum_q <= SUM_W'(s);
      end else begin
        if (s < min_q) min_q <= s;
        if (s > max_q) max_q <= s;
        sum_q <= sum_q + SUM_W'(s);
      end
    end else if (cmd_i.div_step) begin
      sum_q <= SUM_W'(div_prod[DIV_SHIFT +: SAMPLE_BITS]);
    end
  end

  // Shared millivolt scaling multiplier.
  always_comb begin
    case (cmd_i.scale_sel)
      SEL_MEAN: code = 12'(sum_q[SAMPLE_BITS-1:0]);
      SEL_MIN:  code = 12'(min_q);
      SEL_MAX:  code = 12'(max_q);
      default:  code = '0;
    endcase
  end

  assign prod = 28'(code) * 28'(MV_SCALE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      case (cmd_i.scale_sel)
        SEL_MEAN: mean_mv_q <= prod[27:16];
        SEL_MIN:  min_mv_q  <= prod[27:16];
        SEL_MAX:  max_mv_q  <= prod[27:16];
        default:  mean_mv_q <= mean_mv_q;
      endcase
    end
  end

  assign mean_dg = split_mv(mean_mv_q);
  assign min_dg  = split_mv(min_mv_q);
  assign max_dg  = split_mv(max_mv_q);

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mean_mv_o               <= mean_mv_q;
      min_mv_o                <= min_mv_q;
      max_mv_o                <= max_mv_q;
      mean_volts_digit_o      <= mean_dg.volts;
      mean_tenths_digit_o     <= mean_dg.tenths;
      mean_hundredths_digit_o <= mean_dg.hundredths;
      min_volts_digit_o       <= min_dg.volts;
      min_tenths_digit_o      <= min_dg.tenths;
      min_hundredths_digit_o  <= min_dg.hundredths;
      max_volts_digit_o       <= max_dg.volts;
      max_tenths_digit_o      <= max_dg.tenths;
      max_hundredths_digit_o  <= max_dg.hundredths;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// File: rtl/adc_window_min_max_mean.sv
// After the window's last sample word is accepted, the result word passes through the divide,
// scale and emit states, and waits longer if the previous result is still stalled. The block
// takes one sample word per cycle inside a window, then stalls its input per window to form
// the mean by reciprocal multiplication, scale three values and load the result.
// Reset (rst_ni low, asynchronous) empties the window and drops any pending result.
module adc_window_min_max_mean #(
  parameter int unsigned WINDOW      = 20,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] mean_mv_o,
  output logic [11:0] min_mv_o,
  output logic [11:0] max_mv_o,
  output logic [1:0]  mean_volts_digit_o,
  output logic [3:0]  mean_tenths_digit_o,
  output logic [3:0]  mean_hundredths_digit_o,
  output logic [1:0]  min_volts_digit_o,
  output logic [3:0]  min_tenths_digit_o,
  output logic [3:0]  min_hundredths_digit_o,
  output logic [1:0]  max_volts_digit_o,
  output logic [3:0]  max_tenths_digit_o,
  output logic [3:0]  max_hundredths_digit_o
);
  import adcwmm_pkg::*;

  // The block collects WINDOW sample words, tracking minimum, maximum and
  // sum. The word that completes a window is part of its statistics. The
  // controller then divides the sum by WINDOW, multiplying by a rounded-up
  // reciprocal, and feeds mean, minimum and maximum in turn through one
  // multiplier that scales a code to millivolts by 52800 / 2^16. A final
  // step splits the three values into digits and loads the result register,
  // which waits for the output side while a new window fills.

  ctrl_cmd_t  cmd;
  dp_status_t status;

  adcwmm_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adcwmm_dp #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .sample_i                (sample_i),
    .cmd_i                   (cmd),
    .status_o                (status),
    .out_stall_i             (out_stall_i),
    .out_valid_o             (out_valid_o),
    .mean_mv_o               (mean_mv_o),
    .min_mv_o                (min_mv_o),
    .max_mv_o                (max_mv_o),
    .mean_volts_digit_o      (mean_volts_digit_o),
    .mean_tenths_digit_o     (mean_tenths_digit_o),
    .mean_hundredths_digit_o (mean_hundredths_digit_o),
    .min_volts_digit_o       (min_volts_digit_o),
    .min_tenths_digit_o      (min_tenths_digit_o),
    .min_hundredths_digit_o  (min_hundredths_digit_o),
    .max_volts_digit_o       (max_volts_digit_o),
    .max_tenths_digit_o      (max_tenths_digit_o),
    .max_hundredths_digit_o  (max_hundredths_digit_o)
  );

  // A new result never overwrites one that is still held by a stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && out_stall_i))
    else $error("result overwritten while stalled");

  // Loading the result register always presents a word next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not presented");

  // Scaling is monotonic, so the mean lies between minimum and maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_mv_o <= mean_mv_o) && (mean_mv_o <= max_mv_o))
    else $error("mean outside minimum and maximum");

  // The mean digits rebuild the millivolt value to within ten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({20'd0, mean_mv_o} - {30'd0, mean_volts_digit_o} * 32'd1000
                     - {28'd0, mean_tenths_digit_o} * 32'd100
                     - {28'd0, mean_hundredths_digit_o} * 32'd10) < 32'd10)
    else $error("mean digits do not match millivolts");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  // The block runs at its default geometry: windows of 20 words, full 12-bit codes.
  localparam int unsigned WINDOW         = 20;
  localparam int unsigned SAMPLE_BITS    = 12;
  // About 1700 sample words in all: one directed window, then random windows.
  localparam int unsigned RANDOM_WINDOWS = 84;
  // Besides division and scaling, a result word can sit behind a long receiver stall, so a
  // quiet stretch far longer than that means the block is stuck.
  localparam int unsigned IDLE_LIMIT     = 2000;
  // Cycles to keep watching after the last expected word, so a stray extra word gets caught.
  localparam int unsigned DRAIN_CYCLES   = 40;

  // One result word, fields in the same order as the output ports.
  typedef struct packed {
    logic [11:0] mean_mv;
    logic [11:0] min_mv;
    logic [11:0] max_mv;
    logic [1:0]  mean_volts;
    logic [3:0]  mean_tenths;
    logic [3:0]  mean_hundredths;
    logic [1:0]  min_volts;
    logic [3:0]  min_tenths;
    logic [3:0]  min_hundredths;
    logic [1:0]  max_volts;
    logic [3:0]  max_tenths;
    logic [3:0]  max_hundredths;
  } stats_word_t;

  // One row of the directed table. When typed is set, word is the result that row must produce.
  typedef struct {
    logic [11:0] sample;
    bit          typed;
    stats_word_t word;
  } dir_row_t;

  // Shapes of random windows. Anything past WIN_UNIFORM in the draw is uniform as well, so
  // uniform windows dominate while rails, flat and bit-pattern windows still come up often.
  typedef enum int unsigned {
    WIN_ZEROS,
    WIN_FULL,
    WIN_RAILS,
    WIN_NARROW,
    WIN_ONE_HOT,
    WIN_UNIFORM
  } window_kind_e;

  // Receiver behavior, held for a random number of cycles before the next draw.
  typedef enum int unsigned {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [11:0] sample_i    = '0;
  logic        out_stall_i = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [11:0] mean_mv_o, min_mv_o, max_mv_o;
  logic [1:0]  mean_volts_digit_o, min_volts_digit_o, max_volts_digit_o;
  logic [3:0]  mean_tenths_digit_o, mean_hundredths_digit_o;
  logic [3:0]  min_tenths_digit_o, min_hundredths_digit_o;
  logic [3:0]  max_tenths_digit_o, max_hundredths_digit_o;
  stats_word_t dut_word;

  adc_window_min_max_mean #(
    .WINDOW     (WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .sample_i               (sample_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .mean_mv_o              (mean_mv_o),
    .min_mv_o               (min_mv_o),
    .max_mv_o               (max_mv_o),
    .mean_volts_digit_o     (mean_volts_digit_o),
    .mean_tenths_digit_o    (mean_tenths_digit_o),
    .mean_hundredths_digit_o(mean_hundredths_digit_o),
    .min_volts_digit_o      (min_volts_digit_o),
    .min_tenths_digit_o     (min_tenths_digit_o),
    .min_hundredths_digit_o (min_hundredths_digit_o),
    .max_volts_digit_o      (max_volts_digit_o),
    .max_tenths_digit_o     (max_tenths_digit_o),
    .max_hundredths_digit_o (max_hundredths_digit_o)
  );

  assign dut_word = {mean_mv_o, min_mv_o, max_mv_o,
                     mean_volts_digit_o, mean_tenths_digit_o, mean_hundredths_digit_o,
                     min_volts_digit_o, min_tenths_digit_o, min_hundredths_digit_o,
                     max_volts_digit_o, max_tenths_digit_o, max_hundredths_digit_o};

  always #5 clk_i = ~clk_i;

  // Our own copy of the window statistics, advanced once per accepted sample word.
  logic [4:0]  win_count = '0;
  logic [11:0] win_min   = 12'hFFF;
  logic [11:0] win_max   = '0;
  logic [16:0] win_sum   = '0;

  // Result words still owed by the block, oldest first.
  stats_word_t pending_stats[$];

  int unsigned errors        = 0;
  int unsigned samples_sent  = 0;
  int unsigned words_checked = 0;
  int unsigned idle_cycles   = 0;
  int unsigned burst_left    = 0;
  int unsigned stall_left    = 0;
  stall_mode_e stall_mode    = STALL_NONE;

  // Millivolt scaling: code * 0.80566 done as code * 52800 >> 16, keeping 12 bits.
  function automatic logic [11:0] code_to_mv(input logic [11:0] code);
    logic [31:0] prod;
    prod = 32'(code) * 32'd52800;
    return prod[27:16];
  endfunction

  // Splits millivolts into {volts, tenths, hundredths}.
  function automatic logic [9:0] mv_digits(input logic [11:0] mv);
    logic [31:0] m, v, t, h;
    m = 32'(mv);
    v = m / 1000;
    t = (m % 1000) / 100;
    h = (m % 100) / 10;
    return {v[1:0], t[3:0], h[3:0]};
  endfunction

  function automatic stats_word_t build_word(input logic [11:0] mean_code,
                                             input logic [11:0] min_code,
                                             input logic [11:0] max_code);
    stats_word_t w;
    w.mean_mv = code_to_mv(mean_code);
    w.min_mv  = code_to_mv(min_code);
    w.max_mv  = code_to_mv(max_code);
    {w.mean_volts, w.mean_tenths, w.mean_hundredths} = mv_digits(w.mean_mv);
    {w.min_volts, w.min_tenths, w.min_hundredths}    = mv_digits(w.min_mv);
    {w.max_volts, w.max_tenths, w.max_hundredths}    = mv_digits(w.max_mv);
    return w;
  endfunction

  // Folds one sample into the running window. The first word of a window reloads min, max
  // and sum outright; the last one closes the window, and only then is a word returned.
  function automatic bit fold_sample(input logic [11:0] raw, output stats_word_t word);
    logic [11:0] s;
    s = raw & 12'((1 << SAMPLE_BITS) - 1);
    word = '0;
    if (win_count == 0) begin
      win_min = s;
      win_max = s;
      win_sum = 17'(s);
    end else begin
      if (s < win_min) win_min = s;
      if (s > win_max) win_max = s;
      win_sum = win_sum + 17'(s);
    end
    if (win_count + 1 < WINDOW) begin
      win_count = win_count + 1;
      return 1'b0;
    end
    win_count = '0;
    word = build_word(12'(win_sum / WINDOW), win_min, win_max);
    return 1'b1;
  endfunction

  // Sender. Words go out in bursts; when a burst runs out, valid drops for a short random gap.
  // Some bursts are long, so there are stretches with no idling on the input at all. The
  // expectation is worked out at the edge where the word is taken.
  task automatic push_sample(input logic [11:0] s, input bit typed, input stats_word_t typed_word);
    stats_word_t word;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    burst_left--;
    samples_sent++;
    if (fold_sample(s, word)) pending_stats.push_back(typed ? typed_word : word);
  endtask

  function automatic logic [11:0] random_sample(input window_kind_e kind,
                                                input logic [11:0] center);
    logic [11:0] w;
    case (kind)
      WIN_ZEROS:   w = 12'h000;
      WIN_FULL:    w = 12'hFFF;
      WIN_RAILS:   w = ($urandom_range(0, 1) == 0) ? 12'h000 : 12'hFFF;
      WIN_NARROW:  w = center ^ 12'($urandom_range(0, 31));
      WIN_ONE_HOT: begin
        w = 12'h001 << $urandom_range(0, 11);
        if ($urandom_range(0, 1) == 0) w = ~w;
      end
      default:     w = 12'($urandom_range(0, 4095));
    endcase
    return w;
  endfunction

  task automatic check_field(input string field, input logic [11:0] want, input logic [11:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  task automatic compare_word(input stats_word_t want, input stats_word_t got);
    check_field("mean_mv", want.mean_mv, got.mean_mv);
    check_field("min_mv", want.min_mv, got.min_mv);
    check_field("max_mv", want.max_mv, got.max_mv);
    check_field("mean_volts_digit", 12'(want.mean_volts), 12'(got.mean_volts));
    check_field("mean_tenths_digit", 12'(want.mean_tenths), 12'(got.mean_tenths));
    check_field("mean_hundredths_digit", 12'(want.mean_hundredths), 12'(got.mean_hundredths));
    check_field("min_volts_digit", 12'(want.min_volts), 12'(got.min_volts));
    check_field("min_tenths_digit", 12'(want.min_tenths), 12'(got.min_tenths));
    check_field("min_hundredths_digit", 12'(want.min_hundredths), 12'(got.min_hundredths));
    check_field("max_volts_digit", 12'(want.max_volts), 12'(got.max_volts));
    check_field("max_tenths_digit", 12'(want.max_tenths), 12'(got.max_tenths));
    check_field("max_hundredths_digit", 12'(want.max_hundredths), 12'(got.max_hundredths));
  endtask

  // Receiver. It switches between never stalling, coin flips, mostly stalled and strict
  // alternation, holding each mode for a random stretch so stalls land on every phase.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(STALL_NONE, STALL_TOGGLE));
      stall_left = $urandom_range(10, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_COIN:  out_stall_i <= ($urandom_range(0, 1) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 7) != 0);
      default:     out_stall_i <= ~out_stall_i;
    endcase
  end

  // Every result word taken from the block is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t: result word taken with none expected, got mean_mv %0d", $time, mean_mv_o);
      end else begin
        compare_word(pending_stats.pop_front(), dut_word);
        words_checked++;
      end
    end
  end

  // A long run of cycles with no word moving on either side means the block has hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("adc_window_min_max_mean: mismatch");
      $finish;
    end
  end

  initial begin
    dir_row_t     dir_rows[WINDOW];
    stats_word_t  full_scale;
    window_kind_e kind;
    logic [11:0]  center;
    int unsigned  draw;

    // Full-scale codes everywhere give 3299 mV on all three statistics, i.e. 3.29 V.
    full_scale = '{mean_mv: 12'd3299, min_mv: 12'd3299, max_mv: 12'd3299,
                   mean_volts: 2'd3, mean_tenths: 4'd2, mean_hundredths: 4'd9,
                   min_volts: 2'd3, min_tenths: 4'd2, min_hundredths: 4'd9,
                   max_volts: 2'd3, max_tenths: 4'd2, max_hundredths: 4'd9};

    // Directed part: the first window after reset, all at full scale. It checks that the
    // window closes on its last word, that the sum of a window of maximum codes divides back
    // to full scale, and the top of the scaling and digit split. Only the closing row owes
    // a result.
    for (int i = 0; i < WINDOW; i++) begin
      dir_rows[i] = '{sample: 12'hFFF, typed: (i == WINDOW - 1), word: full_scale};
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) push_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].word);

    // Random part: whole windows of a random shape, so each window ends on a real result and
    // the reload of min and max on a window's first word is exercised over and over.
    for (int w = 0; w < RANDOM_WINDOWS; w++) begin
      draw   = $urandom_range(0, 9);
      kind   = (draw > WIN_UNIFORM) ? WIN_UNIFORM : window_kind_e'(draw);
      center = 12'($urandom_range(0, 4095));
      for (int j = 0; j < WINDOW; j++) push_sample(random_sample(kind, center), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d sample words in %0d windows (full scale first, then random shapes).",
             samples_sent, samples_sent / WINDOW);
    $display("Checked %0d result words field by field under random input gaps and output stalls.",
             words_checked);
    if (errors == 0) begin
      $display("adc_window_min_max_mean: match");
    end else begin
      $display("adc_window_min_max_mean: mismatch");
    end
    $finish;
  end

endmodule
